// ===== rtl/core/joystick_key_input_qualifier_macros.svh =====
// ----------------------------------------------------------------------------
// Joystick key input qualifier assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_KEY_INPUT_QUALIFIER_MACROS_SVH
`define JOYSTICK_KEY_INPUT_QUALIFIER_MACROS_SVH

// same-cycle implication
`define JKIQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JKIQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/jkiq_pkg.sv =====
// ----------------------------------------------------------------------------
// Joystick key input qualifier package
// Widths, operation and register codes, control word bits and the key map.
// ----------------------------------------------------------------------------
`default_nettype none

package jkiq_pkg;

	localparam int AXIS_BITS = 16;

	typedef logic [AXIS_BITS-1:0] axis_t;

	typedef enum logic [2:0] {
		OP_KEY_DOWN  = 3'd0,
		OP_KEY_UP    = 3'd1,
		OP_POLL_CTRL = 3'd2,
		OP_POLL_TAPS = 3'd3,
		OP_RECAL     = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_JOY_EN = 3'd0,
		CFG_MIN_X  = 3'd1,
		CFG_MAX_X  = 3'd2,
		CFG_MIN_Y  = 3'd3,
		CFG_MAX_Y  = 3'd4
	} cfg_idx_t;

	localparam logic [7:0] BIT_UP = 8'h01;
	localparam logic [7:0] BIT_DN = 8'h02;
	localparam logic [7:0] BIT_LF = 8'h04;
	localparam logic [7:0] BIT_RT = 8'h08;
	localparam logic [7:0] BIT_B1 = 8'h10;
	localparam logic [7:0] BIT_B2 = 8'h20;
	localparam logic [7:0] BIT_B3 = 8'h40;
	localparam logic [7:0] BIT_B4 = 8'h80;

	// per-axis tracking result
	typedef struct packed {
		axis_t min_v;
		axis_t max_v;
		logic  neg;
		logic  pos;
	} axis_res_t;

	function automatic logic [7:0] key_bit(input logic [7:0] code);
		logic [7:0] b;
		b = 8'h00;
		case (code) inside
			8'h68, 8'h26:        b = BIT_UP;
			8'h62, 8'h28:        b = BIT_DN;
			8'h64, 8'h25:        b = BIT_LF;
			8'h66, 8'h27:        b = BIT_RT;
			8'h5A, 8'h11, 8'h0D: b = BIT_B1;
			8'h58, 8'h10, 8'h20: b = BIT_B2;
			8'h41, 8'h2D, 8'h6D: b = BIT_B3;
			8'h53, 8'h3D, 8'h6B: b = BIT_B4;
			default:             b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jkiq_axis.sv =====
// ----------------------------------------------------------------------------
// Joystick axis qualifier
// Widens the tracked range with a sample and flags travel past the dead zone.
// ----------------------------------------------------------------------------
`default_nettype none

module jkiq_axis (
	input  wire jkiq_pkg::axis_t    sample,
	input  wire jkiq_pkg::axis_t    track_min,
	input  wire jkiq_pkg::axis_t    track_max,
	input  wire jkiq_pkg::axis_t    center,
	output jkiq_pkg::axis_res_t     res
);

	localparam int W = jkiq_pkg::AXIS_BITS;

	jkiq_pkg::axis_t         new_min;
	jkiq_pkg::axis_t         new_max;
	jkiq_pkg::axis_t         dead;
	logic signed [W+1:0]     diff;
	logic signed [W+1:0]     dead_s;

	always_comb begin
		new_min = (sample < track_min) ? sample : track_min;
		new_max = (sample > track_max) ? sample : track_max;
		dead    = (new_max >= new_min) ? ((new_max - new_min) >> 3) : '0;
		diff    = signed'({2'b00, sample}) - signed'({2'b00, center});
		dead_s  = signed'({2'b00, dead});
		res.min_v = new_min;
		res.max_v = new_max;
		res.neg   = (diff < -dead_s);
		res.pos   = (diff > dead_s);
	end

endmodule

`default_nettype wire

// ===== rtl/core/joystick_key_input_qualifier.sv =====
// ----------------------------------------------------------------------------
// Joystick key input qualifier
// Merges key events and joystick samples into an 8-bit control word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event per transaction:
//   key down, key up, poll controls, poll taps or recalibrate. Polls return
//   one control_bits transaction on the output channel (out_valid/out_stall);
//   other events return nothing.
//   A transaction accepted into the input register is evaluated there against
//   the block state; a poll's result is registered in the result register
//   once that is free, and offered from then on.
//   Throughput: one transaction per cycle, set by the single evaluation stage
//   between the input and result registers, while in_stall stays low.
//   When the receiver stalls, the held result stays put and one more
//   transaction is taken into the input register; in_stall rises only when
//   a poll waits there behind the held result. Key and recalibrate events
//   keep flowing past a stalled result. Configuration writes (cfg_valid/
//   cfg_ready, ready always high) must go in while the block is idle; the
//   block does not check it. Reset clears key, tap and button history, sets
//   the tracked range to empty and the joystick to active and enabled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joystick_key_input_qualifier_macros.svh"

module joystick_key_input_qualifier (
	input  wire                     clk,
	input  wire                     arst_n,

	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire [2:0]               cfg_index,
	input  wire jkiq_pkg::axis_t    cfg_data,

	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire [2:0]               opcode,
	input  wire [7:0]               key_code,
	input  wire jkiq_pkg::axis_t    joy_x,
	input  wire jkiq_pkg::axis_t    joy_y,
	input  wire [3:0]               joy_buttons,
	input  wire                     joy_ok,

	output logic                    out_valid,
	input  wire                     out_stall,
	output logic [7:0]              control_bits
);

	localparam int W = jkiq_pkg::AXIS_BITS;

	// configuration
	logic               joy_en_q;
	jkiq_pkg::axis_t    cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;

	// input register
	logic               valid_s1;
	logic [2:0]         opcode_s1;
	logic [7:0]         key_code_s1;
	jkiq_pkg::axis_t    joy_x_s1, joy_y_s1;
	logic [3:0]         joy_buttons_s1;
	logic               joy_ok_s1;

	// block state
	logic [7:0]         held_q, tap_q;
	logic [3:0]         prev_btn_q;
	jkiq_pkg::axis_t    min_x_q, max_x_q, min_y_q, max_y_q, ctr_x_q, ctr_y_q;
	logic               joy_active_q;

	logic [7:0]         held_d, tap_d;
	logic [3:0]         prev_btn_d;
	jkiq_pkg::axis_t    min_x_d, max_x_d, min_y_d, max_y_d, ctr_x_d, ctr_y_d;
	logic               joy_active_d;

	// result register
	logic               out_valid_q;
	logic [7:0]         ctrl_q;

	logic               in_use, has_res, out_free, adv, in_acc;
	logic [7:0]         kb, word, rise8, res_word;
	logic [W:0]         sum_x, sum_y;
	jkiq_pkg::opcode_t  op;
	jkiq_pkg::axis_res_t ax_x, ax_y;

	jkiq_axis u_axis_x (
		.sample    (joy_x_s1),
		.track_min (min_x_q),
		.track_max (max_x_q),
		.center    (ctr_x_q),
		.res       (ax_x)
	);

	jkiq_axis u_axis_y (
		.sample    (joy_y_s1),
		.track_min (min_y_q),
		.track_max (max_y_q),
		.center    (ctr_y_q),
		.res       (ax_y)
	);

	// handshake
	always_comb begin
		op       = jkiq_pkg::opcode_t'(opcode_s1);
		has_res  = (op == jkiq_pkg::OP_POLL_CTRL) || (op == jkiq_pkg::OP_POLL_TAPS);
		out_free = !out_valid_q || !out_stall;
		adv      = valid_s1 && (out_free || !has_res);
		in_stall = valid_s1 && !adv;
		in_acc   = in_valid && !in_stall;
	end

	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign control_bits = ctrl_q;

	// evaluation
	always_comb begin
		in_use   = joy_active_q && joy_en_q;
		kb       = jkiq_pkg::key_bit(key_code_s1);
		sum_x    = {1'b0, cal_min_x_q} + {1'b0, cal_max_x_q};
		sum_y    = {1'b0, cal_min_y_q} + {1'b0, cal_max_y_q};
		rise8    = {joy_buttons_s1 & ~prev_btn_q, 4'b0000};
		word     = 8'h00;
		res_word = 8'h00;

		held_d       = held_q;
		tap_d        = tap_q;
		prev_btn_d   = prev_btn_q;
		min_x_d      = min_x_q;
		max_x_d      = max_x_q;
		min_y_d      = min_y_q;
		max_y_d      = max_y_q;
		ctr_x_d      = ctr_x_q;
		ctr_y_d      = ctr_y_q;
		joy_active_d = joy_active_q;

		case (op)
			jkiq_pkg::OP_KEY_DOWN: begin
				held_d = held_q | kb;
				tap_d  = tap_q | kb;
			end
			jkiq_pkg::OP_KEY_UP: begin
				held_d = held_q & ~kb;
			end
			jkiq_pkg::OP_POLL_CTRL, jkiq_pkg::OP_POLL_TAPS: begin
				if (in_use) begin
					if (!joy_ok_s1) begin
						joy_active_d = 1'b0;
					end else begin
						min_x_d    = ax_x.min_v;
						max_x_d    = ax_x.max_v;
						min_y_d    = ax_y.min_v;
						max_y_d    = ax_y.max_v;
						prev_btn_d = joy_buttons_s1;
						tap_d      = tap_q | rise8;
						word       = {joy_buttons_s1, 4'b0000}
							| (ax_x.neg ? jkiq_pkg::BIT_LF : 8'h00)
							| (ax_x.pos ? jkiq_pkg::BIT_RT : 8'h00)
							| (ax_y.neg ? jkiq_pkg::BIT_UP : 8'h00)
							| (ax_y.pos ? jkiq_pkg::BIT_DN : 8'h00);
					end
				end
				if (op == jkiq_pkg::OP_POLL_CTRL) begin
					res_word = held_q | word;
				end else begin
					res_word = tap_d;
					tap_d    = 8'h00;
				end
			end
			jkiq_pkg::OP_RECAL: begin
				if (in_use) begin
					if (!joy_ok_s1) begin
						joy_active_d = 1'b0;
					end else begin
						min_x_d    = cal_min_x_q;
						max_x_d    = cal_max_x_q;
						min_y_d    = cal_min_y_q;
						max_y_d    = cal_max_y_q;
						ctr_x_d    = sum_x[W:1];
						ctr_y_d    = sum_y[W:1];
						prev_btn_d = 4'h0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_en_q    <= 1'b1;
			cal_min_x_q <= '0;
			cal_max_x_q <= '1;
			cal_min_y_q <= '0;
			cal_max_y_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (jkiq_pkg::cfg_idx_t'(cfg_index))
				jkiq_pkg::CFG_JOY_EN: joy_en_q    <= cfg_data[0];
				jkiq_pkg::CFG_MIN_X:  cal_min_x_q <= cfg_data;
				jkiq_pkg::CFG_MAX_X:  cal_max_x_q <= cfg_data;
				jkiq_pkg::CFG_MIN_Y:  cal_min_y_q <= cfg_data;
				jkiq_pkg::CFG_MAX_Y:  cal_max_y_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			opcode_s1      <= opcode;
			key_code_s1    <= key_code;
			joy_x_s1       <= joy_x;
			joy_y_s1       <= joy_y;
			joy_buttons_s1 <= joy_buttons;
			joy_ok_s1      <= joy_ok;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= 8'h00;
			tap_q        <= 8'h00;
			prev_btn_q   <= 4'h0;
			min_x_q      <= '1;
			max_x_q      <= '0;
			min_y_q      <= '1;
			max_y_q      <= '0;
			ctr_x_q      <= '0;
			ctr_y_q      <= '0;
			joy_active_q <= 1'b1;
		end else if (adv) begin
			held_q       <= held_d;
			tap_q        <= tap_d;
			prev_btn_q   <= prev_btn_d;
			min_x_q      <= min_x_d;
			max_x_q      <= max_x_d;
			min_y_q      <= min_y_d;
			max_y_q      <= max_y_d;
			ctr_x_q      <= ctr_x_d;
			ctr_y_q      <= ctr_y_d;
			joy_active_q <= joy_active_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			ctrl_q <= res_word;
		end
	end

	`JKIQ_ASSERT_NOW(a_stall_backlog, clk, arst_n, in_stall, valid_s1 && out_valid_q && has_res, "input stalled without a poll waiting behind a held result")
	`JKIQ_ASSERT_NEXT(a_poll_result, clk, arst_n, adv && has_res, out_valid, "poll transaction produced no result")
	`JKIQ_ASSERT_NEXT(a_tap_clear, clk, arst_n, adv && (op == jkiq_pkg::OP_POLL_TAPS), tap_q == 8'h00, "tap latch not cleared after tap poll")
	`JKIQ_ASSERT_NOW(a_joy_drop, clk, arst_n, $fell(joy_active_q), $past(adv && !joy_ok_s1 && (has_res || (op == jkiq_pkg::OP_RECAL))), "joystick disabled without a failed sample")

endmodule

`default_nettype wire

// ===== tb/joystick_key_input_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick key input qualifier testbench
// Sends key, poll and recalibrate transactions under several idle and stall
// mixes and across axis range settings. A local model predicts each control
// word, and every result is checked in order against it.
// ----------------------------------------------------------------------------

module joystick_key_input_qualifier_tb;
	import jkiq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 4;
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		logic [2:0] op;
		logic [7:0] key;
		axis_t      x;
		axis_t      y;
		logic [3:0] btn;
		logic       ok;
	} joy_event_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	axis_t      cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] opcode;
	logic [7:0] key_code;
	axis_t      joy_x;
	axis_t      joy_y;
	logic [3:0] joy_buttons;
	logic       joy_ok;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] control_bits;

	// model state and register copies
	logic [7:0] held_bits    = 8'h00;
	logic [7:0] tap_bits     = 8'h00;
	logic [3:0] last_buttons = 4'h0;
	axis_t      lo_x = '1, hi_x = '0, lo_y = '1, hi_y = '0;
	axis_t      mid_x = '0, mid_y = '0;
	logic       joy_live = 1'b1;
	logic       en_reg   = 1'b1;
	axis_t      cal_lo_x = '0, cal_hi_x = '1, cal_lo_y = '0, cal_hi_y = '1;

	logic [7:0] expected_words[$];
	int         mismatches    = 0;
	int         idle_cycles   = 0;
	int         send_idle_pct = 0;
	int         stall_pct     = 0;

	logic [7:0] mapped_keys [0:21] = '{
		8'h68, 8'h26, 8'h62, 8'h28, 8'h64, 8'h25, 8'h66, 8'h27,
		8'h5A, 8'h11, 8'h0D, 8'h58, 8'h10, 8'h20, 8'h41, 8'h2D,
		8'h6D, 8'h53, 8'h3D, 8'h6B, 8'h00, 8'hFF
	};

	joystick_key_input_qualifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.key_code     (key_code),
		.joy_x        (joy_x),
		.joy_y        (joy_y),
		.joy_buttons  (joy_buttons),
		.joy_ok       (joy_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.control_bits (control_bits)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] key_to_bit(input logic [7:0] code);
		case (code)
			8'h68, 8'h26:        return BIT_UP;
			8'h62, 8'h28:        return BIT_DN;
			8'h64, 8'h25:        return BIT_LF;
			8'h66, 8'h27:        return BIT_RT;
			8'h5A, 8'h11, 8'h0D: return BIT_B1;
			8'h58, 8'h10, 8'h20: return BIT_B2;
			8'h41, 8'h2D, 8'h6D: return BIT_B3;
			8'h53, 8'h3D, 8'h6B: return BIT_B4;
			default:             return 8'h00;
		endcase
	endfunction

	// {above, below} for one axis; dead zone is range/8, zero when inverted
	function automatic logic [1:0] axis_dir(input axis_t v, input axis_t lo,
			input axis_t hi, input axis_t c);
		longint dead;
		longint diff;
		dead = (hi >= lo) ? longint'((hi - lo) >> 3) : 0;
		diff = longint'(v) - longint'(c);
		return {diff > dead, diff < -dead};
	endfunction

	function automatic logic [7:0] take_sample(input joy_event_t ev);
		logic [1:0] dx;
		logic [1:0] dy;
		logic [3:0] rise;
		logic [7:0] w;
		if (!(joy_live && en_reg))
			return 8'h00;
		if (!ev.ok) begin
			joy_live = 1'b0;
			return 8'h00;
		end
		if (ev.x < lo_x) lo_x = ev.x;
		if (ev.x > hi_x) hi_x = ev.x;
		if (ev.y < lo_y) lo_y = ev.y;
		if (ev.y > hi_y) hi_y = ev.y;
		dx = axis_dir(ev.x, lo_x, hi_x, mid_x);
		dy = axis_dir(ev.y, lo_y, hi_y, mid_y);
		rise = ev.btn & ~last_buttons;
		tap_bits |= {rise, 4'h0};
		last_buttons = ev.btn;
		w = {ev.btn, 4'h0};
		if (dx[0]) w |= BIT_LF;
		if (dx[1]) w |= BIT_RT;
		if (dy[0]) w |= BIT_UP;
		if (dy[1]) w |= BIT_DN;
		return w;
	endfunction

	task automatic apply_event(input joy_event_t ev);
		logic [7:0]         w;
		logic [AXIS_BITS:0] sum;
		case (ev.op)
			OP_KEY_DOWN: begin
				held_bits |= key_to_bit(ev.key);
				tap_bits  |= key_to_bit(ev.key);
			end
			OP_KEY_UP: held_bits &= ~key_to_bit(ev.key);
			OP_POLL_CTRL: begin
				w = take_sample(ev);
				expected_words.push_back(held_bits | w);
			end
			OP_POLL_TAPS: begin
				w = take_sample(ev);
				expected_words.push_back(tap_bits);
				tap_bits = 8'h00;
			end
			OP_RECAL: begin
				if (joy_live && en_reg) begin
					if (!ev.ok) begin
						joy_live = 1'b0;
					end else begin
						lo_x = cal_lo_x;
						hi_x = cal_hi_x;
						lo_y = cal_lo_y;
						hi_y = cal_hi_y;
						sum = {1'b0, cal_lo_x} + {1'b0, cal_hi_x};
						mid_x = sum[AXIS_BITS:1];
						sum = {1'b0, cal_lo_y} + {1'b0, cal_hi_y};
						mid_y = sum[AXIS_BITS:1];
						last_buttons = 4'h0;
					end
				end
			end
			default: ;
		endcase
	endtask

	function automatic joy_event_t make_event(input logic [2:0] op, input logic [7:0] key,
			input axis_t x, input axis_t y, input logic [3:0] btn, input logic ok);
		joy_event_t ev;
		ev.op  = op;
		ev.key = key;
		ev.x   = x;
		ev.y   = y;
		ev.btn = btn;
		ev.ok  = ok;
		return ev;
	endfunction

	function automatic axis_t rand_axis(input axis_t c);
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			2, 3:    return c + axis_t'($urandom_range(8191)) - axis_t'(4096);
			default: return axis_t'($urandom);
		endcase
	endfunction

	function automatic axis_t rand_cal();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return axis_t'($urandom);
		endcase
	endfunction

	function automatic joy_event_t rand_event();
		joy_event_t ev;
		int         r;
		r = $urandom_range(99);
		if (r < 25)      ev.op = OP_KEY_DOWN;
		else if (r < 45) ev.op = OP_KEY_UP;
		else if (r < 70) ev.op = OP_POLL_CTRL;
		else if (r < 87) ev.op = OP_POLL_TAPS;
		else if (r < 95) ev.op = OP_RECAL;
		else             ev.op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
		ev.key = ($urandom_range(3) == 0) ? 8'($urandom) : mapped_keys[$urandom_range(21)];
		ev.x   = rand_axis(mid_x);
		ev.y   = rand_axis(mid_y);
		ev.btn = 4'($urandom);
		// a failed read would lose the joystick for good, so only when unused
		ev.ok  = (joy_live && en_reg) ? 1'b1 : 1'($urandom);
		return ev;
	endfunction

	task automatic send_event(input joy_event_t ev);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= ev.op;
		key_code    <= ev.key;
		joy_x       <= ev.x;
		joy_y       <= ev.y;
		joy_buttons <= ev.btn;
		joy_ok      <= ev.ok;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		apply_event(ev);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input axis_t val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		case (idx)
			CFG_JOY_EN: en_reg   = val[0];
			CFG_MIN_X:  cal_lo_x = val;
			CFG_MAX_X:  cal_hi_x = val;
			CFG_MIN_Y:  cal_lo_y = val;
			CFG_MAX_Y:  cal_hi_y = val;
			default: ;
		endcase
	endtask

	task automatic set_cfg(input logic en, input axis_t lox, input axis_t hix,
			input axis_t loy, input axis_t hiy);
		axis_t en_word;
		en_word = axis_t'($urandom);
		en_word[0] = en;
		write_reg(CFG_JOY_EN, en_word);
		write_reg(CFG_MIN_X, lox);
		write_reg(CFG_MAX_X, hix);
		write_reg(CFG_MIN_Y, loy);
		write_reg(CFG_MAX_Y, hiy);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_key_events();
		send_event(make_event(OP_POLL_CTRL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_KEY_DOWN, 8'h26, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_KEY_DOWN, 8'h6B, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_KEY_DOWN, 8'hFF, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_KEY_DOWN, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_TAPS, 8'h00, '1, '1, 4'hF, 1'b1));
		send_event(make_event(OP_KEY_UP, 8'h26, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_KEY_UP, 8'h55, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, '1, '0, 4'h5, 1'b1));
		send_event(make_event(OP_SPARE_5, 8'hFF, '1, '1, 4'hF, 1'b1));
		send_event(make_event(OP_SPARE_6, 8'hFF, '1, '1, 4'hF, 1'b0));
		send_event(make_event(OP_SPARE_7, 8'h26, '1, '1, 4'hF, 1'b1));
		send_event(make_event(OP_POLL_TAPS, 8'h00, 16'h8000, 16'h8000, 4'hA, 1'b1));
		drain();
	endtask

	task automatic test_axis_extremes();
		set_cfg(1'b1, '0, '1, '0, '1);
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, '0, '1, 4'h3, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, 16'h7FFF, 16'h8000, 4'hC, 1'b1));
		drain();
		// inverted range gives no dead zone
		set_cfg(1'b1, '1, '0, '1, '0);
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, 16'h8000, 16'h7FFE, 4'h1, 1'b1));
		send_event(make_event(OP_POLL_TAPS, 8'h00, '0, '1, 4'h1, 1'b1));
		drain();
		set_cfg(1'b1, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, 16'h1235, 16'h1233, 4'h0, 1'b1));
		drain();
		// disabled joystick ignores failed reads
		set_cfg(1'b0, '0, '1, '0, '1);
		send_event(make_event(OP_POLL_CTRL, 8'h00, '1, '1, 4'hF, 1'b0));
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b0));
		send_event(make_event(OP_POLL_TAPS, 8'h00, '0, '0, 4'hF, 1'b0));
		drain();
	endtask

	task automatic test_random(input int items, input int idle, input int stall);
		joy_event_t ev;
		int         sent;
		sent = 0;
		set_cfg($urandom_range(3) != 0, rand_cal(), rand_cal(), rand_cal(), rand_cal());
		send_idle_pct = idle;
		stall_pct     = stall;
		while (sent < items) begin
			ev = rand_event();
			send_event(ev);
			if (ev.op <= OP_RECAL)
				sent++;
		end
		drain();
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	// joystick loss is permanent, so it runs last
	task automatic test_lost_joystick();
		set_cfg(1'b1, '0, '1, '0, '1);
		send_idle_pct = 26;
		stall_pct     = 26;
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, '0, '1, 4'h6, 1'b1));
		send_event(make_event(OP_KEY_DOWN, 8'h5A, '0, '0, 4'h0, 1'b1));
		if ($urandom_range(1) != 0)
			send_event(make_event(OP_POLL_CTRL, 8'h00, '1, '0, 4'hF, 1'b0));
		else
			send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b0));
		send_event(make_event(OP_POLL_CTRL, 8'h00, '1, '0, 4'hF, 1'b1));
		send_event(make_event(OP_POLL_TAPS, 8'h00, '0, '1, 4'h9, 1'b1));
		send_event(make_event(OP_RECAL, 8'h00, '0, '0, 4'h0, 1'b1));
		send_event(make_event(OP_POLL_CTRL, 8'h00, 16'h4000, 16'hC000, 4'h2, 1'b1));
		for (int i = 0; i < 30; i++)
			send_event(rand_event());
		drain();
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: control_bits expected none actual %h", $time, control_bits);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (control_bits !== want) begin
					$display("%0t: control_bits expected %h actual %h",
						$time, want, control_bits);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_JOY_EN;
		cfg_data    = '0;
		in_valid    = 1'b0;
		opcode      = OP_KEY_DOWN;
		key_code    = 8'h00;
		joy_x       = '0;
		joy_y       = '0;
		joy_buttons = 4'h0;
		joy_ok      = 1'b1;
		out_stall   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_key_events();
		test_axis_extremes();
		test_random(250, 0, 0);
		test_random(250, 56, 0);
		test_random(250, 0, 56);
		test_random(250, 26, 26);
		test_lost_joystick();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
